// File: rtl/sc1a_pkg.sv
// Package for the set 1 scancode to ASCII decoder.
// Holds scancode constants, register indexes, the ASCII lookup tables and shared types.
// No dependencies.
package sc1a_pkg;

   localparam int SCAN_W = 8;
   localparam int CODE_W = 9;
   localparam int ROM_DEPTH = 58;
   localparam int ROM_IDX_W = 6;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [SCAN_W-1:0] SC_LSHIFT = 8'h2A;
   localparam logic [SCAN_W-1:0] SC_RSHIFT = 8'h36;
   localparam logic [SCAN_W-1:0] SC_LSHIFT_BRK = 8'hAA;
   localparam logic [SCAN_W-1:0] SC_RSHIFT_BRK = 8'hB6;
   localparam logic [SCAN_W-1:0] SC_PREFIX = 8'hE0;
   localparam logic [SCAN_W-1:0] SC_UP = 8'h48;
   localparam logic [SCAN_W-1:0] SC_DOWN = 8'h50;
   localparam logic [SCAN_W-1:0] SC_LEFT = 8'h4B;
   localparam logic [SCAN_W-1:0] SC_RIGHT = 8'h4D;
   localparam logic [SCAN_W-1:0] SC_ENTER = 8'h1C;
   localparam logic [SCAN_W-1:0] SC_BKSP = 8'h0E;
   localparam logic [CODE_W-1:0] CODE_NL = 9'h00A;
   localparam logic [CODE_W-1:0] CODE_BKSP = 9'h008;

   localparam logic [CODE_W-1:0] UP_RESET = 9'd256;
   localparam logic [CODE_W-1:0] DOWN_RESET = 9'd257;
   localparam logic [CODE_W-1:0] LEFT_RESET = 9'd258;
   localparam logic [CODE_W-1:0] RIGHT_RESET = 9'd259;

   typedef enum logic [1:0] {
      REG_UP    = 2'd0,
      REG_DOWN  = 2'd1,
      REG_LEFT  = 2'd2,
      REG_RIGHT = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [CODE_W-1:0] up;
      logic [CODE_W-1:0] down;
      logic [CODE_W-1:0] left;
      logic [CODE_W-1:0] right;
   } arrow_codes_type;

   localparam logic [7:0] ROM_PLAIN [ROM_DEPTH] = '{
      8'h00, 8'h00, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
      8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h00, 8'h00,
      8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
      8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h00, 8'h00,
      8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B,
      8'h6C, 8'h3B, 8'h27, 8'h60, 8'h00, 8'h5C,
      8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E, 8'h6D, 8'h2C,
      8'h2E, 8'h2F, 8'h00, 8'h2A, 8'h00, 8'h20
   };

   localparam logic [7:0] ROM_SHIFT [ROM_DEPTH] = '{
      8'h00, 8'h00, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
      8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h00, 8'h00,
      8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
      8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h00, 8'h00,
      8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B,
      8'h4C, 8'h3A, 8'h22, 8'h7E, 8'h00, 8'h7C,
      8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E, 8'h4D, 8'h3C,
      8'h3E, 8'h3F, 8'h00, 8'h2A, 8'h00, 8'h20
   };

endpackage

// File: rtl/sc1a_csr.sv
// Arrow code registers behind the APB-style configuration port.
// Depends on sc1a_pkg.
module sc1a_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [sc1a_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [sc1a_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [sc1a_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                             pready,
   output sc1a_pkg::arrow_codes_type        codes
);

   sc1a_pkg::arrow_codes_type codes_ff, codes_in;
   sc1a_pkg::reg_index_type   reg_idx;
   logic [sc1a_pkg::CODE_W-1:0] wdata;
   logic [sc1a_pkg::CODE_W-1:0] rdata;
   logic                        wr_en;

   assign reg_idx = sc1a_pkg::reg_index_type'(paddr[3:2]);
   assign wdata   = pwdata[sc1a_pkg::CODE_W-1:0];
   assign wr_en   = psel & penable & pwrite;
   assign pready  = 1'b1;

   always_comb begin
      codes_in = codes_ff;
      if (wr_en) begin
         case (reg_idx)
            sc1a_pkg::REG_UP:    codes_in.up    = wdata;
            sc1a_pkg::REG_DOWN:  codes_in.down  = wdata;
            sc1a_pkg::REG_LEFT:  codes_in.left  = wdata;
            sc1a_pkg::REG_RIGHT: codes_in.right = wdata;
            default:             codes_in = codes_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         sc1a_pkg::REG_UP:    rdata = codes_ff.up;
         sc1a_pkg::REG_DOWN:  rdata = codes_ff.down;
         sc1a_pkg::REG_LEFT:  rdata = codes_ff.left;
         sc1a_pkg::REG_RIGHT: rdata = codes_ff.right;
         default:             rdata = '0;
      endcase
   end

   assign prdata = {{(sc1a_pkg::CSR_DATA_W-sc1a_pkg::CODE_W){1'b0}}, rdata};
   assign codes  = codes_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         codes_ff.up    <= sc1a_pkg::UP_RESET;
         codes_ff.down  <= sc1a_pkg::DOWN_RESET;
         codes_ff.left  <= sc1a_pkg::LEFT_RESET;
         codes_ff.right <= sc1a_pkg::RIGHT_RESET;
      end else begin
         codes_ff <= codes_in;
      end
   end

endmodule

// File: rtl/sc1a_decode.sv
// Scancode decode: shift and extended-prefix flags plus ASCII table lookup.
// Depends on sc1a_pkg.
module sc1a_decode (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            advance,
   input  logic [sc1a_pkg::SCAN_W-1:0]     scan_byte,
   input  sc1a_pkg::arrow_codes_type       codes,
   output logic                            hit,
   output logic [sc1a_pkg::CODE_W-1:0]     key_code
);

   logic shift_ff, shift_in;
   logic prefix_ff, prefix_in;
   logic [sc1a_pkg::ROM_IDX_W-1:0] rom_idx;
   logic [7:0] rom_val;

   assign rom_idx = scan_byte[sc1a_pkg::ROM_IDX_W-1:0];
   assign rom_val = shift_ff ? sc1a_pkg::ROM_SHIFT[rom_idx] : sc1a_pkg::ROM_PLAIN[rom_idx];

   always_comb begin
      shift_in  = shift_ff;
      prefix_in = prefix_ff;
      hit       = 1'b0;
      key_code  = '0;
      if (prefix_ff) begin
         prefix_in = 1'b0;
         hit = 1'b1;
         case (scan_byte)
            sc1a_pkg::SC_UP:    key_code = codes.up;
            sc1a_pkg::SC_DOWN:  key_code = codes.down;
            sc1a_pkg::SC_LEFT:  key_code = codes.left;
            sc1a_pkg::SC_RIGHT: key_code = codes.right;
            default:            hit = 1'b0;
         endcase
      end else if (scan_byte == sc1a_pkg::SC_LSHIFT || scan_byte == sc1a_pkg::SC_RSHIFT) begin
         shift_in = 1'b1;
      end else if (scan_byte == sc1a_pkg::SC_LSHIFT_BRK
                   || scan_byte == sc1a_pkg::SC_RSHIFT_BRK) begin
         shift_in = 1'b0;
      end else if (scan_byte == sc1a_pkg::SC_PREFIX) begin
         prefix_in = 1'b1;
      end else if (scan_byte[7]) begin
         hit = 1'b0;
      end else if (scan_byte == sc1a_pkg::SC_ENTER) begin
         hit = 1'b1;
         key_code = sc1a_pkg::CODE_NL;
      end else if (scan_byte == sc1a_pkg::SC_BKSP) begin
         hit = 1'b1;
         key_code = sc1a_pkg::CODE_BKSP;
      end else if (scan_byte < 8'(sc1a_pkg::ROM_DEPTH)) begin
         hit = (rom_val != 8'h00);
         key_code = {1'b0, rom_val};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff  <= 1'b0;
         prefix_ff <= 1'b0;
      end else if (advance) begin
         shift_ff  <= shift_in;
         prefix_ff <= prefix_in;
      end
   end

endmodule

// File: rtl/scancode_set1_to_ascii_core.sv
// Top level of the set 1 scancode to ASCII decoder.
// Depends on sc1a_pkg, sc1a_csr and sc1a_decode.
//
// Usage:
//   Request channel (req_valid, req_stall, req_scan_byte) takes one raw
//   scancode byte per request. Response channel (rsp_valid, rsp_stall,
//   rsp_key_code) returns zero or one key code per request, in order.
//   Shift, shift release, the 0xE0 prefix, other releases and unmapped keys
//   give no response; the byte after 0xE0 gives a response only for arrows.
//   A request accepted into the input register is decoded from it, and its
//   response is then captured in the response register when not blocked.
//   Throughput: one request per cycle while no response is held; the input
//   and response registers form a two-stage pipeline with no bubbles.
//   When rsp_stall holds a pending response, the input register stalls and
//   req_stall rises while it holds a request; otherwise requests keep flowing.
//   Reset clears the pipeline, the shift and prefix flags, and loads the arrow
//   codes with 256..259. The user must write arrow codes over the csr_ port
//   at byte addresses 0, 4, 8, 12 only while the block is idle (not enforced).
module scancode_set1_to_ascii_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [sc1a_pkg::SCAN_W-1:0]        req_scan_byte,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [sc1a_pkg::CODE_W-1:0]        rsp_key_code,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [sc1a_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [sc1a_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [sc1a_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready
);

   sc1a_pkg::arrow_codes_type codes;

   logic                          s1_valid_ff, s1_valid_in;
   logic [sc1a_pkg::SCAN_W-1:0]   s1_byte_ff, s1_byte_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [sc1a_pkg::CODE_W-1:0]   rsp_code_ff, rsp_code_in;
   logic                          out_blocked;
   logic                          s1_adv;
   logic                          dec_hit;
   logic [sc1a_pkg::CODE_W-1:0]   dec_code;

   sc1a_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .codes   (codes)
   );

   sc1a_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .advance   (s1_adv),
      .scan_byte (s1_byte_ff),
      .codes     (codes),
      .hit       (dec_hit),
      .key_code  (dec_code)
   );

   assign out_blocked = rsp_valid_ff & rsp_stall;
   assign s1_adv      = s1_valid_ff & ~out_blocked;
   assign req_stall   = s1_valid_ff & out_blocked;

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_byte_in   = s1_byte_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_code_in  = rsp_code_ff;
      if (!req_stall) begin
         s1_valid_in = req_valid;
         s1_byte_in  = req_scan_byte;
      end
      if (!out_blocked) begin
         rsp_valid_in = s1_adv & dec_hit;
         rsp_code_in  = dec_code;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      s1_byte_ff  <= s1_byte_in;
      rsp_code_ff <= rsp_code_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_key_code = rsp_code_ff;

   a_stall_needs_full_output: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid_ff && s1_valid_ff))
      else $error("request stalled without a held response");

   a_held_request_stable: assert property (@(posedge clock) disable iff (reset)
      req_stall |=> (s1_valid_ff && $stable(s1_byte_ff)))
      else $error("held request changed while output blocked");

   a_hit_reaches_output: assert property (@(posedge clock) disable iff (reset)
      (s1_adv && dec_hit) |=> (rsp_valid_ff && rsp_code_ff == $past(dec_code)))
      else $error("decoded key code lost on its way to the response register");

endmodule

// File: tb/tb_scancode_set1_to_ascii_core.sv
// Self-checking testbench for scancode_set1_to_ascii_core: directed scancode table, then random
// key sequences over several arrow-code settings and idle/stall mixes, scoreboarded in order.
// Depends on sc1a_pkg and the RTL of the core.
module tb_scancode_set1_to_ascii_core;

   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 300;
   localparam int TAIL_CYCLES = 8;

   typedef enum logic [1:0] {
      CHK_MODEL = 2'd0,
      CHK_NONE  = 2'd1,
      CHK_CODE  = 2'd2
   } check_kind_type;

   typedef struct packed {
      logic [sc1a_pkg::SCAN_W-1:0] scan;
      check_kind_type              chk;
      logic [sc1a_pkg::CODE_W-1:0] code;
   } dir_row_type;

   localparam int DIR_ROWS = 30;

   logic [7:0] plain_tab [sc1a_pkg::ROM_DEPTH] = '{
      8'h00, 8'h00, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
      8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h00, 8'h00,
      8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69, 8'h6F, 8'h70, 8'h5B, 8'h5D,
      8'h00, 8'h00,
      8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B, 8'h27, 8'h60,
      8'h00, 8'h5C,
      8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A,
      8'h00, 8'h20
   };

   logic [7:0] shift_tab [sc1a_pkg::ROM_DEPTH] = '{
      8'h00, 8'h00, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
      8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h00, 8'h00,
      8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49, 8'h4F, 8'h50, 8'h7B, 8'h7D,
      8'h00, 8'h00,
      8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A, 8'h22, 8'h7E,
      8'h00, 8'h7C,
      8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A,
      8'h00, 8'h20
   };

   dir_row_type dir_tab [DIR_ROWS] = '{
      '{8'h00,                   CHK_NONE,  9'h000},
      '{sc1a_pkg::SC_ENTER,      CHK_CODE,  9'h00A},
      '{sc1a_pkg::SC_BKSP,       CHK_CODE,  9'h008},
      '{8'h02,                   CHK_MODEL, 9'h000},
      '{sc1a_pkg::SC_LSHIFT,     CHK_NONE,  9'h000},
      '{8'h10,                   CHK_MODEL, 9'h000},
      '{8'h39,                   CHK_MODEL, 9'h000},
      '{sc1a_pkg::SC_LSHIFT_BRK, CHK_NONE,  9'h000},
      '{8'h10,                   CHK_MODEL, 9'h000},
      '{sc1a_pkg::SC_RSHIFT,     CHK_NONE,  9'h000},
      '{8'h35,                   CHK_MODEL, 9'h000},
      '{sc1a_pkg::SC_RSHIFT_BRK, CHK_NONE,  9'h000},
      '{sc1a_pkg::SC_PREFIX,     CHK_NONE,  9'h000},
      '{sc1a_pkg::SC_UP,         CHK_CODE,  9'd256},
      '{sc1a_pkg::SC_PREFIX,     CHK_NONE,  9'h000},
      '{sc1a_pkg::SC_DOWN,       CHK_CODE,  9'd257},
      '{sc1a_pkg::SC_PREFIX,     CHK_NONE,  9'h000},
      '{sc1a_pkg::SC_LEFT,       CHK_CODE,  9'd258},
      '{sc1a_pkg::SC_PREFIX,     CHK_NONE,  9'h000},
      '{sc1a_pkg::SC_RIGHT,      CHK_CODE,  9'd259},
      '{sc1a_pkg::SC_PREFIX,     CHK_NONE,  9'h000},
      '{sc1a_pkg::SC_PREFIX,     CHK_NONE,  9'h000},
      '{sc1a_pkg::SC_ENTER,      CHK_CODE,  9'h00A},
      '{sc1a_pkg::SC_PREFIX,     CHK_NONE,  9'h000},
      '{sc1a_pkg::SC_LSHIFT,     CHK_NONE,  9'h000},
      '{8'h1E,                   CHK_MODEL, 9'h000},
      '{8'h9E,                   CHK_NONE,  9'h000},
      '{8'h3A,                   CHK_NONE,  9'h000},
      '{8'hFF,                   CHK_NONE,  9'h000},
      '{8'h37,                   CHK_MODEL, 9'h000}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [sc1a_pkg::SCAN_W-1:0] req_scan_byte = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [sc1a_pkg::CODE_W-1:0] rsp_key_code;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [sc1a_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [sc1a_pkg::CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [sc1a_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   // decoder shadow state
   logic shift_q = 1'b0;
   logic prefix_q = 1'b0;
   sc1a_pkg::arrow_codes_type codes_q = '{sc1a_pkg::UP_RESET, sc1a_pkg::DOWN_RESET,
                                          sc1a_pkg::LEFT_RESET, sc1a_pkg::RIGHT_RESET};

   logic [sc1a_pkg::CODE_W-1:0] key_code_q [$];
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   bit hold_req = 1'b0;
   int hold_left = 0;
   int fail_cnt = 0;
   int n_req = 0;
   int n_rsp = 0;
   int n_cfg = 0;
   int cycles = 0;

   scancode_set1_to_ascii_core dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_scan_byte (req_scan_byte),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_key_code  (rsp_key_code),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("status: fail");
         $finish;
      end
   end

   function automatic logic decode_scan(input logic [sc1a_pkg::SCAN_W-1:0] b,
                                        output logic [sc1a_pkg::CODE_W-1:0] code);
      code = '0;
      if (prefix_q) begin
         prefix_q = 1'b0;
         case (b)
            sc1a_pkg::SC_UP:    code = codes_q.up;
            sc1a_pkg::SC_DOWN:  code = codes_q.down;
            sc1a_pkg::SC_LEFT:  code = codes_q.left;
            sc1a_pkg::SC_RIGHT: code = codes_q.right;
            default:            return 1'b0;
         endcase
         return 1'b1;
      end
      if (b == sc1a_pkg::SC_LSHIFT || b == sc1a_pkg::SC_RSHIFT) begin
         shift_q = 1'b1;
         return 1'b0;
      end
      if (b == sc1a_pkg::SC_LSHIFT_BRK || b == sc1a_pkg::SC_RSHIFT_BRK) begin
         shift_q = 1'b0;
         return 1'b0;
      end
      if (b == sc1a_pkg::SC_PREFIX) begin
         prefix_q = 1'b1;
         return 1'b0;
      end
      if (b[sc1a_pkg::SCAN_W-1]) return 1'b0;
      if (b == sc1a_pkg::SC_ENTER) begin
         code = sc1a_pkg::CODE_NL;
         return 1'b1;
      end
      if (b == sc1a_pkg::SC_BKSP) begin
         code = sc1a_pkg::CODE_BKSP;
         return 1'b1;
      end
      if (b < sc1a_pkg::ROM_DEPTH) begin
         code = {1'b0, shift_q ? shift_tab[b] : plain_tab[b]};
         return code != '0;
      end
      return 1'b0;
   endfunction

   // receiver: random stall, or a long hold-off when requested
   always @(posedge clock) begin
      if (hold_req) begin
         hold_req = 1'b0;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         n_rsp++;
         if (key_code_q.size() == 0) begin
            $error("unexpected response: key_code actual %0h", rsp_key_code);
            fail_cnt++;
         end else begin
            if (rsp_key_code !== key_code_q[0]) begin
               $error("key_code mismatch: expected %0h actual %0h",
                      key_code_q[0], rsp_key_code);
               fail_cnt++;
            end
            void'(key_code_q.pop_front());
         end
      end
   end

   task automatic send_scan(input logic [sc1a_pkg::SCAN_W-1:0] b, input check_kind_type chk,
                            input logic [sc1a_pkg::CODE_W-1:0] typed_code);
      logic got;
      logic [sc1a_pkg::CODE_W-1:0] code;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_scan_byte <= b;
      do @(posedge clock); while (req_stall);
      n_req++;
      got = decode_scan(b, code);
      case (chk)
         CHK_MODEL: if (got) key_code_q.push_back(code);
         CHK_CODE:  key_code_q.push_back(typed_code);
         default:   ;
      endcase
   endtask

   task automatic send_key(input logic [sc1a_pkg::SCAN_W-1:0] b);
      send_scan(b, CHK_MODEL, '0);
   endtask

   task automatic drain(input int tail);
      req_valid <= 1'b0;
      while (key_code_q.size() != 0) @(posedge clock);
      repeat (tail) @(posedge clock);
   endtask

   task automatic csr_write(input sc1a_pkg::reg_index_type idx,
                            input logic [sc1a_pkg::CSR_DATA_W-1:0] data);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      n_cfg++;
      case (idx)
         sc1a_pkg::REG_UP:    codes_q.up = data[sc1a_pkg::CODE_W-1:0];
         sc1a_pkg::REG_DOWN:  codes_q.down = data[sc1a_pkg::CODE_W-1:0];
         sc1a_pkg::REG_LEFT:  codes_q.left = data[sc1a_pkg::CODE_W-1:0];
         sc1a_pkg::REG_RIGHT: codes_q.right = data[sc1a_pkg::CODE_W-1:0];
         default:             ;
      endcase
   endtask

   task automatic set_codes(input logic [sc1a_pkg::CSR_DATA_W-1:0] up,
                            input logic [sc1a_pkg::CSR_DATA_W-1:0] down,
                            input logic [sc1a_pkg::CSR_DATA_W-1:0] left,
                            input logic [sc1a_pkg::CSR_DATA_W-1:0] right);
      drain(TAIL_CYCLES);
      csr_write(sc1a_pkg::REG_UP, up);
      csr_write(sc1a_pkg::REG_DOWN, down);
      csr_write(sc1a_pkg::REG_LEFT, left);
      csr_write(sc1a_pkg::REG_RIGHT, right);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   // mostly well-formed key sequences, some noise
   task automatic send_random(input int n_items);
      int sent;
      int kind;
      logic [sc1a_pkg::SCAN_W-1:0] key;
      logic [sc1a_pkg::SCAN_W-1:0] sh;
      logic [sc1a_pkg::SCAN_W-1:0] arrow;
      sent = 0;
      while (sent < n_items) begin
         kind = $urandom_range(99);
         key = sc1a_pkg::SCAN_W'($urandom_range(sc1a_pkg::ROM_DEPTH - 1));
         sh = $urandom_range(1) ? sc1a_pkg::SC_LSHIFT : sc1a_pkg::SC_RSHIFT;
         case ($urandom_range(3))
            0: arrow = sc1a_pkg::SC_UP;
            1: arrow = sc1a_pkg::SC_DOWN;
            2: arrow = sc1a_pkg::SC_LEFT;
            default: arrow = sc1a_pkg::SC_RIGHT;
         endcase
         if (kind < 35) begin
            send_key(key);
            send_key(key | 8'h80);
            sent += 2;
         end else if (kind < 52) begin
            send_key(sh);
            send_key(key);
            send_key(key | 8'h80);
            send_key(sh | 8'h80);
            sent += 4;
         end else if (kind < 70) begin
            send_key(sc1a_pkg::SC_PREFIX);
            send_key(arrow);
            send_key(sc1a_pkg::SC_PREFIX);
            send_key(arrow | 8'h80);
            sent += 4;
         end else if (kind < 78) begin
            send_key(sc1a_pkg::SC_PREFIX);
            send_key(sc1a_pkg::SCAN_W'($urandom_range(255)));
            sent += 2;
         end else if (kind < 90) begin
            send_key(key);
            sent++;
         end else begin
            send_key(sc1a_pkg::SCAN_W'($urandom_range(255)));
            sent++;
         end
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < DIR_ROWS; i++)
         send_scan(dir_tab[i].scan, dir_tab[i].chk, dir_tab[i].code);
      send_random(100);

      set_codes(32'h0, 32'h0, 32'h0, 32'h0);
      send_idle_pct = 68;
      send_random(140);

      send_idle_pct = 0;
      set_codes(32'h1FF, 32'h1FF, 32'h1FF, 32'h1FF);
      rsp_stall_pct = 68;
      hold_req = 1'b1;
      send_random(140);

      rsp_stall_pct = 0;
      set_codes($urandom, $urandom, $urandom, $urandom);
      send_idle_pct = 13;
      rsp_stall_pct = 13;
      send_random(70);
      drain(0);
      send_random(70);

      send_idle_pct = 0;
      rsp_stall_pct = 0;
      set_codes(32'h0, 32'h1FF, {23'h0, 9'($urandom)}, 32'hFFFF_FE00);
      send_random(140);

      set_codes($urandom, $urandom, $urandom, $urandom);
      send_idle_pct = 13;
      rsp_stall_pct = 13;
      send_random(140);

      drain(TAIL_CYCLES);
      $display("summary: %0d scancode requests, %0d key codes checked, %0d register writes",
               n_req, n_rsp, n_cfg);
      $display("covered shift, extended prefix, arrows at reset/min/max/random codes, releases");
      if (fail_cnt == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/sc1a_pkg.sv
rtl/sc1a_csr.sv
rtl/sc1a_decode.sv
rtl/scancode_set1_to_ascii_core.sv
tb/tb_scancode_set1_to_ascii_core.sv
